// ----- hdl/fbfl_pkg.sv -----
// Shared types and constants of the fixed block free list allocator.
package fbfl_pkg;

    // Pool depth and derived widths.
    localparam int MAX_BLOCKS = 256;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int LIM_W      = IDX_W + SIZE_W;
    localparam int STEP_W     = $clog2(IDX_W);

    // Result status codes.
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED    = 2'd1;
    localparam logic [1:0] ST_NONE_USED    = 2'd2;
    localparam logic [1:0] ST_OUT_OF_RANGE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_POOL_BASE   = 2'd0;
    localparam logic [1:0] REG_BLOCK_SIZE  = 2'd1;
    localparam logic [1:0] REG_BLOCK_COUNT = 2'd2;

    // Request codes.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Effective configuration seen by the datapath.
    typedef struct packed {
        logic [ADDR_W-1:0] pool_base;
        logic [SIZE_W-1:0] block_size;
        logic [CNT_W-1:0]  block_count;
    } cfg_t;

    // One classified request waiting in the queue.
    typedef struct packed {
        logic              is_free;
        logic [ADDR_W-1:0] offset;
    } queue_item_t;

    // Status of the execution side, visible to the top level.
    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] used;
    } back_stat_t;

endpackage

// ----- hdl/fixed_block_free_list_allocator_top.sv -----
// Top level of the fixed block free list allocator: configuration registers and assertions.
//
// The block hands out and takes back equal-sized blocks of a pool starting at pool_base.
// Input channel (in_valid / in_stall): req_type 0 allocates, 1 frees free_address.
// Output channel (out_valid / out_stall): one result transaction per request, carrying
// block_address, status and used_count after that request.
// Configuration: cfg_we with cfg_index and cfg_wdata writes pool_base (0), block_size (1)
// or block_count (2); any such write empties the pool. Index 3 is ignored.
// Steps from acceptance to result: a granted allocate reads the stack memory, then does
// one multiply and one add; an accepted free runs an 8-step restoring divider producing
// one quotient bit per cycle, then writes the stack; a rejected request skips both.
// The execution sequencer handles one request at a time while a two-entry queue keeps
// taking new transactions.
// Reset empties the pool and loads pool_base 0, block_size 64, block_count 256; the
// stack needs no clearing pass because per-slot valid bits mark untouched slots.
// While the receiver stalls, the result is held; one more request can finish into a
// waiting slot of the sequencer and the queue fills before in_stall rises.
module fixed_block_free_list_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] free_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] block_address,
    output logic [1:0]  status,
    output logic [8:0]  used_count,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import fbfl_pkg::*;

    logic [ADDR_W-1:0]  pool_base_reg;
    logic [SIZE_W-1:0]  block_size_reg;
    logic [CNT_W-1:0]   block_count_reg;
    logic               refill;
    cfg_t               cfg;
    logic               q_valid;
    queue_item_t        q_item;
    logic               q_pop;
    back_stat_t         stat;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg   <= '0;
            block_size_reg  <= SIZE_W'(64);
            block_count_reg <= CNT_W'(MAX_BLOCKS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POOL_BASE:   pool_base_reg   <= cfg_wdata;
                REG_BLOCK_SIZE:  block_size_reg  <= cfg_wdata[SIZE_W-1:0];
                REG_BLOCK_COUNT: block_count_reg <= cfg_wdata[CNT_W-1:0];
                default:         pool_base_reg   <= pool_base_reg;
            endcase
        end
    end

    // A write to any existing register refills the stack.
    always_comb
    begin
        refill = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index) inside
                REG_POOL_BASE, REG_BLOCK_SIZE, REG_BLOCK_COUNT: refill = 1'b1;
                default:                                        refill = 1'b0;
            endcase
        end
    end

    // Effective configuration: a zero size acts as one, the count is clamped to the depth.
    always_comb
    begin
        cfg.pool_base   = pool_base_reg;
        cfg.block_size  = (block_size_reg == '0) ? SIZE_W'(1) : block_size_reg;
        cfg.block_count = (block_count_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                                 : block_count_reg;
    end

    fbfl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .free_address (free_address),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    fbfl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .refill        (refill),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .block_address (block_address),
        .status        (status),
        .used_count    (used_count),
        .stat          (stat)
    );

`ifndef NO_ASSERTIONS
    // Any failed request or free returns address zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> block_address == '0)
        else $error("failed request returned a nonzero address");

    // A refill write leaves the pool empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        refill |=> stat.used == '0)
        else $error("used count not cleared by configuration write");

    // The used count never passes the effective block count.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.used <= cfg.block_count || $past(refill))
        else $error("used count beyond block count");

    // A queued request starts only when the sequencer is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && !stat.busy)
        else $error("request dequeued while sequencer busy");
`endif

endmodule

// ----- hdl/fbfl_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
module fbfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/fbfl_front.sv -----
// Request front end: accepts transactions, forms the pool offset and queues them.
module fbfl_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        req_type,
    input  logic [31:0]                 free_address,
    input  fbfl_pkg::cfg_t              cfg,
    output logic                        q_valid,
    output fbfl_pkg::queue_item_t       q_item,
    input  logic                        q_pop
);
    import fbfl_pkg::*;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);

    queue_item_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_next;
    logic [QPTR_W:0]         fill_reg;
    logic [QPTR_W:0]         fill_next;
    logic                    push;
    queue_item_t             new_item;

    // Classify the request and compute its offset into the pool.
    always_comb
    begin
        new_item.is_free = (req_type == REQ_FREE);
        new_item.offset  = free_address - cfg.pool_base;
    end

    assign in_stall = (fill_reg == (QPTR_W+1)'(QDEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    // Queue pointer and fill level update.
    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !q_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

// ----- hdl/fbfl_back.sv -----
// Execution side: free index stack, allocate and free sequencing, result register.
module fbfl_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  fbfl_pkg::cfg_t              cfg,
    input  logic                        refill,
    input  logic                        q_valid,
    input  fbfl_pkg::queue_item_t       q_item,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [31:0]                 block_address,
    output logic [1:0]                  status,
    output logic [8:0]                  used_count,
    output fbfl_pkg::back_stat_t        stat
);
    import fbfl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLASS = 3'd1;
    localparam logic [2:0] S_ARD   = 3'd2;
    localparam logic [2:0] S_AADD  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_FWR   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [CNT_W-1:0]        used_reg;
    logic [CNT_W-1:0]        used_next;
    logic [MAX_BLOCKS-1:0]   valid_bits_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;

    logic                    item_free_reg;
    logic [ADDR_W-1:0]       item_off_reg;
    logic                    vbit_reg;
    logic                    vbit_next;
    logic [LIM_W-1:0]        limit_reg;
    logic [LIM_W-1:0]        prod_reg;
    logic [LIM_W-1:0]        prod_next;
    logic [LIM_W-1:0]        rem_reg;
    logic [LIM_W-1:0]        rem_next;
    logic [IDX_W-1:0]        quo_reg;
    logic [IDX_W-1:0]        quo_next;
    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    logic [ADDR_W-1:0]       res_addr_reg;
    logic [ADDR_W-1:0]       res_addr_next;
    logic [1:0]              res_status_reg;
    logic [1:0]              res_status_next;
    logic [ADDR_W-1:0]       out_addr_reg;
    logic [1:0]              out_status_reg;
    logic [CNT_W-1:0]        out_used_reg;

    logic                    ram_rd_en;
    logic                    ram_wr_en;
    logic [IDX_W-1:0]        ram_rd_data;
    logic [IDX_W-1:0]        used_dec_idx;
    logic [IDX_W-1:0]        pop_idx;
    logic [LIM_W-1:0]        div_sub;
    logic                    div_ge;
    logic                    load_out;

    // Stack storage of free block indices.
    fbfl_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_BLOCKS)
    ) u_stack (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (used_dec_idx),
        .wr_data (quo_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (used_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    assign used_dec_idx = IDX_W'(used_reg - 1'b1);
    // A slot never written since refill holds its own index.
    assign pop_idx      = vbit_reg ? ram_rd_data : used_reg[IDX_W-1:0];
    assign div_sub      = LIM_W'(cfg.block_size) << step_reg;
    assign div_ge       = (rem_reg >= div_sub);
    assign load_out     = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Sequencer for one request at a time.
    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        q_pop           = 1'b0;
        ram_rd_en       = 1'b0;
        ram_wr_en       = 1'b0;
        vbit_next       = vbit_reg;
        prod_next       = prod_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                res_addr_next   = '0;
                res_status_next = ST_OK;
                if (!item_free_reg)
                begin
                    if (used_reg >= cfg.block_count)
                    begin
                        res_status_next = ST_EXHAUSTED;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        ram_rd_en  = 1'b1;
                        vbit_next  = valid_bits_reg[used_reg[IDX_W-1:0]];
                        state_next = S_ARD;
                    end
                end
                else if (used_reg == '0)
                begin
                    res_status_next = ST_NONE_USED;
                    state_next      = S_DONE;
                end
                else if (item_off_reg >= ADDR_W'(limit_reg))
                begin
                    res_status_next = ST_OUT_OF_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    rem_next   = item_off_reg[LIM_W-1:0];
                    quo_next   = '0;
                    step_next  = STEP_W'(IDX_W - 1);
                    state_next = S_DIV;
                end
            end
            S_ARD:
            begin
                prod_next  = LIM_W'(pop_idx) * LIM_W'(cfg.block_size);
                state_next = S_AADD;
            end
            S_AADD:
            begin
                res_addr_next = cfg.pool_base + ADDR_W'(prod_reg);
                used_next     = used_reg + 1'b1;
                state_next    = S_DONE;
            end
            S_DIV:
            begin
                // One quotient bit per cycle, most significant first.
                if (div_ge)
                begin
                    rem_next = rem_reg - div_sub;
                    quo_next = quo_reg | (IDX_W'(1) << step_reg);
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = S_FWR;
                end
            end
            S_FWR:
            begin
                ram_wr_en  = 1'b1;
                used_next  = used_reg - 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // A configuration write empties the pool.
        if (refill)
        begin
            used_next = '0;
        end
    end

    // Output register hand-off.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
            valid_bits_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (refill)
            begin
                valid_bits_reg <= '0;
            end
            else if (ram_wr_en)
            begin
                valid_bits_reg[used_dec_idx] <= 1'b1;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        limit_reg      <= LIM_W'(cfg.block_count) * LIM_W'(cfg.block_size);
        vbit_reg       <= vbit_next;
        prod_reg       <= prod_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        step_reg       <= step_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (q_pop)
        begin
            item_free_reg <= q_item.is_free;
            item_off_reg  <= q_item.offset;
        end
        if (load_out)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
            out_used_reg   <= used_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign block_address = out_addr_reg;
    assign status        = out_status_reg;
    assign used_count    = out_used_reg;
    assign stat.busy     = (state_reg != S_IDLE);
    assign stat.used     = used_reg;

endmodule

// ----- test/tb_fixed_block_free_list_allocator_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the fixed block free list allocator top level.
module tb_fixed_block_free_list_allocator_top;
    import fbfl_pkg::*;

    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RANDOM_PHASES = 11;
    localparam int PHASE_ITEMS   = 41;
    localparam int MAX_REPORTED  = 100;

    // Register index past the end of the register list; a write there is a no-op.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // One expected result transaction.
    typedef struct packed {
        logic [31:0] block_address;
        logic [1:0]  status;
        logic [8:0]  used_count;
    } pool_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [31:0] free_address;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] block_address;
    logic [1:0]  status;
    logic [8:0]  used_count;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    // Shadow of the pool: free index stack, blocks in use and configuration.
    logic [7:0]   free_stack [MAX_BLOCKS];
    logic [8:0]   in_use;
    logic [31:0]  cur_base;
    logic [15:0]  cur_size;
    logic [8:0]   cur_count;

    pool_result_t pending_results [$];
    logic [31:0]  live_blocks [$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           quiet_mode = 1'b0;

    fixed_block_free_list_allocator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .free_address  (free_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .block_address (block_address),
        .status        (status),
        .used_count    (used_count),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Prints one line per mismatch, capped to keep the log short, and counts them all.
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTED)
            $display("[%0t] MISMATCH: %s", $time, msg);
        error_count++;
    endtask

    // Every block goes back on the stack in index order and nothing is in use.
    task automatic refill_stack();
        for (int i = 0; i < MAX_BLOCKS; i++)
            free_stack[i] = i[7:0];
        in_use = '0;
        live_blocks.delete();
    endtask

    // Works out the result of one accepted request and updates the shadow pool.
    task automatic predict_outcome(input logic req, input logic [31:0] addr);
        pool_result_t want;
        logic [8:0]   count_eff;
        logic [15:0]  size_eff;
        logic [31:0]  offset;
        logic [31:0]  index;
        want.block_address = '0;
        want.status = ST_OK;
        count_eff = (cur_count > MAX_BLOCKS) ? 9'(MAX_BLOCKS) : cur_count;
        size_eff = (cur_size == '0) ? 16'd1 : cur_size;
        if (req == REQ_ALLOC)
        begin
            if (in_use >= count_eff)
                want.status = ST_EXHAUSTED;
            else
            begin
                want.block_address = cur_base + 32'(free_stack[in_use[7:0]]) * 32'(size_eff);
                in_use = in_use + 9'd1;
                live_blocks.push_back(want.block_address);
            end
        end
        else
        begin
            // Nothing in use is checked before the address range.
            if (in_use == '0)
                want.status = ST_NONE_USED;
            else
            begin
                offset = addr - cur_base;
                index = offset / 32'(size_eff);
                if (index >= 32'(count_eff))
                    want.status = ST_OUT_OF_RANGE;
                else
                begin
                    in_use = in_use - 9'd1;
                    free_stack[in_use[7:0]] = index[7:0];
                end
            end
        end
        want.used_count = in_use;
        pending_results.push_back(want);
    endtask

    // Sends one request transaction; starts and ends just after a falling edge.
    task automatic send_request(input logic req, input logic [31:0] addr);
        int gap;
        gap = quiet_mode ? 0 : pick_gap_length();
        repeat (gap) @(negedge clk);
        req_type = req;
        free_address = addr;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_outcome(req, addr);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Holds off until every expected result has arrived and the block has settled.
    task automatic wait_for_idle();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes one configuration register while the block is idle.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        wait_for_idle();
        cfg_index = index;
        cfg_wdata = value;
        cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        case (index)
            REG_POOL_BASE:   cur_base = value;
            REG_BLOCK_SIZE:  cur_size = value[15:0];
            REG_BLOCK_COUNT: cur_count = value[8:0];
            default: ;
        endcase
        if (index != REG_UNUSED)
            refill_stack();
    endtask

    // Reset configuration: empty frees, first allocations, misaligned and out-of-range frees.
    task automatic test_reset_state();
        send_request(REQ_FREE, 32'h0000_0000);
        send_request(REQ_ALLOC, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_ALLOC, 32'h5A5A_A5A5);
        send_request(REQ_FREE, 32'd64 + 32'd5);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_FREE, 32'd256 * 32'd64);
    endtask

    // A write past the register list must leave the pool untouched.
    task automatic test_unused_register();
        write_register(REG_UNUSED, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'h0000_0000);
    endtask

    // Top-of-memory bases, zero and largest block size, oversized block count.
    task automatic test_extreme_config();
        write_register(REG_POOL_BASE, 32'hFFFF_FF00);
        write_register(REG_BLOCK_SIZE, 32'h0000_0000);
        write_register(REG_BLOCK_COUNT, 32'h0000_01FF);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_ALLOC, 32'h0000_0000);
        // Freeing a block that was never handed out is pushed unchecked.
        send_request(REQ_FREE, 32'hFFFF_FFFF);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_FREE, 32'h0000_0000);
        write_register(REG_POOL_BASE, 32'hFFFF_FFFF);
        write_register(REG_BLOCK_SIZE, 32'h0000_FFFF);
        write_register(REG_BLOCK_COUNT, 32'd256);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_FREE, 32'h0000_FFFE + 32'h10);
    endtask

    // Single-block and zero-block pools: exhaustion, range check, double free.
    task automatic test_pool_limits();
        write_register(REG_POOL_BASE, 32'h1000_0000);
        write_register(REG_BLOCK_SIZE, 32'd128);
        write_register(REG_BLOCK_COUNT, 32'd1);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_FREE, 32'h1000_0080);
        send_request(REQ_FREE, 32'h1000_0000);
        send_request(REQ_FREE, 32'h1000_0000);
        write_register(REG_BLOCK_COUNT, 32'd0);
        send_request(REQ_ALLOC, 32'h0000_0000);
        send_request(REQ_FREE, 32'h1000_0000);
    endtask

    // Phases of mostly well-formed allocate/free traffic over random pool shapes.
    task automatic test_random_traffic();
        int          phase;
        int          n;
        int          r;
        int          k;
        int          alloc_pct;
        logic [15:0] size_eff;
        logic [8:0]  count_eff;
        logic [31:0] addr;
        logic [31:0] upper;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            // New pool shape; the first phase rewrites every register.
            if (phase == 0 || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 3))
                    0: addr = 32'h0000_0000;
                    1: addr = 32'hFFFF_FFFF - $urandom_range(0, 4095);
                    default: addr = $urandom();
                endcase
                write_register(REG_POOL_BASE, addr);
            end
            if (phase == 0 || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 5))
                    0: r = 0;
                    1: r = 1;
                    2: r = 65535;
                    3: r = $urandom_range(1, 16);
                    default: r = $urandom_range(1, 65535);
                endcase
                upper = $urandom_range(0, 1) ? $urandom() : 32'h0;
                write_register(REG_BLOCK_SIZE, {upper[15:0], 16'(r)});
            end
            if (phase == 0 || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 9))
                    0: r = 0;
                    1, 2: r = $urandom_range(1, 4);
                    3: r = 256;
                    4: r = $urandom_range(257, 511);
                    5: r = 511;
                    default: r = $urandom_range(5, 255);
                endcase
                upper = $urandom_range(0, 1) ? $urandom() : 32'h0;
                write_register(REG_BLOCK_COUNT, {upper[22:0], 9'(r)});
            end
            count_eff = (cur_count > MAX_BLOCKS) ? 9'(MAX_BLOCKS) : cur_count;
            size_eff = (cur_size == '0) ? 16'd1 : cur_size;
            quiet_mode = ($urandom_range(0, 3) == 0);
            alloc_pct = $urandom_range(35, 75);

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // Sometimes let the pipeline run dry in the middle of a phase.
                if (n == PHASE_ITEMS / 2 && $urandom_range(0, 1) != 0)
                    wait_for_idle();
                r = $urandom_range(0, 99);
                if (r < alloc_pct)
                    send_request(REQ_ALLOC, $urandom());
                else if (r < 90 && live_blocks.size() > 0)
                begin
                    // Free a handed-out block, at times misaligned or freed twice.
                    k = $urandom_range(0, live_blocks.size() - 1);
                    addr = live_blocks[k];
                    if ($urandom_range(0, 3) == 0)
                        addr = addr + $urandom_range(0, size_eff - 1);
                    if ($urandom_range(0, 9) != 0)
                        live_blocks.delete(k);
                    send_request(REQ_FREE, addr);
                end
                else
                begin
                    // Stray frees around the pool edges and anywhere at all.
                    case ($urandom_range(0, 3))
                        0: addr = $urandom();
                        1: addr = cur_base + 32'(count_eff) * 32'(size_eff);
                        2: addr = cur_base - 32'd1;
                        default: addr = cur_base + 32'(count_eff) * 32'(size_eff) - 32'd1;
                    endcase
                    send_request(REQ_FREE, addr);
                end
            end
        end
        quiet_mode = 1'b0;
    endtask

    // Receiver stalls: random runs of stall and no stall; in quiet phases stall drops once the current run ends.
    initial
    begin : stall_driver
        int hold;
        hold = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (quiet_mode)
                out_stall = 1'b0;
            else
            begin
                out_stall = ($urandom_range(0, 99) < 30);
                hold = pick_gap_length();
            end
        end
    end

    // Compares each result transaction with the oldest expected one.
    initial
    begin : result_checker
        pool_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result addr=%h status=%0d used=%0d",
                                              block_address, status, used_count));
                else
                begin
                    want = pending_results.pop_front();
                    if (block_address !== want.block_address)
                        report_mismatch($sformatf("block_address %h, expected %h",
                                                  block_address, want.block_address));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.status));
                    if (used_count !== want.used_count)
                        report_mismatch($sformatf("used_count %0d, expected %0d",
                                                  used_count, want.used_count));
                end
            end
        end
    end

    // Ends a hung run.
    initial
    begin : watchdog
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("tb_fixed_block_free_list_allocator_top: done, errors");
                $finish;
            end
        end
    end

    // Reset, then the tests in turn, then the final verdict.
    initial
    begin : main_sequence
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_ALLOC;
        free_address = '0;
        cfg_we = 1'b0;
        cfg_index = REG_POOL_BASE;
        cfg_wdata = '0;
        cur_base = 32'h0;
        cur_size = 16'd64;
        cur_count = 9'd256;
        refill_stack();
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_unused_register();
        test_extreme_config();
        test_pool_limits();
        test_random_traffic();

        wait_for_idle();
        if (error_count == 0)
            $display("tb_fixed_block_free_list_allocator_top: done, clean");
        else
            $display("tb_fixed_block_free_list_allocator_top: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/fbfl_pkg.sv
hdl/fbfl_ram.sv
hdl/fbfl_front.sv
hdl/fbfl_back.sv
hdl/fixed_block_free_list_allocator_top.sv
test/tb_fixed_block_free_list_allocator_top.sv
